FILE: rtl/iprm_pkg.sv
// Package: shared types and constants of the ICMP probe reply matcher.
`default_nettype none
package iprm_pkg;

    localparam int MaxPacketBytes    = 2048;
    localparam int MaxRouteAddresses = 9;
    localparam logic [7:0] RrOptionType = 8'd7;

    // Verdict codes
    localparam logic [3:0] VerdictNotV4     = 4'd0;
    localparam logic [3:0] VerdictShort     = 4'd1;
    localparam logic [3:0] VerdictTrunc     = 4'd2;
    localparam logic [3:0] VerdictIpSum     = 4'd3;
    localparam logic [3:0] VerdictNotIcmp   = 4'd4;
    localparam logic [3:0] VerdictIcmpSum   = 4'd5;
    localparam logic [3:0] VerdictOtherType = 4'd6;
    localparam logic [3:0] VerdictNoMatch   = 4'd7;
    localparam logic [3:0] VerdictMatch     = 4'd8;

    // Configuration register indexes
    localparam logic [1:0] CfgIpId    = 2'd0;
    localparam logic [1:0] CfgSrcPort = 2'd1;
    localparam logic [1:0] CfgDstPort = 2'd2;
    localparam logic [1:0] CfgRrEn    = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [3:0]  verdict;
        logic [31:0] reply_source;
        logic [7:0]  reply_ttl;
        logic [7:0]  icmp_type;
        logic [7:0]  icmp_code;
        logic [15:0] reply_ip_id;
        logic [7:0]  payload_ttl;
        logic [31:0] route_address;
        logic        last_result;
    } out_item_t;

    // Per-packet summary handed from the front part to the back part
    typedef struct packed {
        logic [3:0]  verdict;
        logic [31:0] reply_source;
        logic [7:0]  reply_ttl;
        logic [7:0]  icmp_type;
        logic [7:0]  icmp_code;
        logic [15:0] reply_ip_id;
        logic [7:0]  payload_ttl;
        logic [3:0]  count;
        logic [8:0][31:0] routes;
    } pkt_summary_t;

    function automatic logic [16:0] oc_add(input logic [16:0] s, input logic [15:0] v);
        logic [16:0] t;
        t = {1'b0, s[15:0]} + {1'b0, v};
        if (t > 17'h0FFFF) t = {1'b0, t[15:0]} + 17'd1;
        return t;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/icmp_probe_reply_matcher.sv
// Top level of the ICMP probe reply matcher.
`default_nettype none
// Takes one IPv4 packet byte per cycle while s_ready is high (s_ channel) and, at the byte
// marked last, queues a per-packet summary; the back part then emits one verdict result
// followed by up to MAX_ROUTE_ADDRESSES route results, one per cycle while m_ready is high
// (m_ channel). Input runs at one byte per cycle, with a two-entry summary queue between
// parse and output; the rate holds while no packet is shorter than its result list.
// No clearing pass after reset. Configuration writes take effect at the next edge.
module icmp_probe_reply_matcher #(
    parameter int MAX_PACKET_BYTES    = iprm_pkg::MaxPacketBytes,
    parameter int MAX_ROUTE_ADDRESSES = iprm_pkg::MaxRouteAddresses
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire iprm_pkg::in_item_t  s_data,
    input  wire logic                s_valid,
    output logic                     s_ready,
    output iprm_pkg::out_item_t      m_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    input  wire logic                cfg_we,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [15:0]         cfg_data
);
    logic [15:0] ip_id_reg, sport_reg, dport_reg;
    logic        rr_reg;
    logic        sum_valid, sum_ready;
    iprm_pkg::pkt_summary_t sum_data;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ip_id_reg <= '0; sport_reg <= '0; dport_reg <= '0; rr_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                iprm_pkg::CfgIpId:    ip_id_reg <= cfg_data;
                iprm_pkg::CfgSrcPort: sport_reg <= cfg_data;
                iprm_pkg::CfgDstPort: dport_reg <= cfg_data;
                default:              rr_reg    <= cfg_data[0];
            endcase
        end
    end

    iprm_front #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES),
        .MAX_ROUTE_ADDRESSES(MAX_ROUTE_ADDRESSES)
    ) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_item(s_data), .in_valid(s_valid), .in_ready(s_ready),
        .exp_ip_id(ip_id_reg), .exp_src_port(sport_reg), .exp_dst_port(dport_reg),
        .rr_enable(rr_reg),
        .sum_valid(sum_valid), .sum_data(sum_data), .sum_ready(sum_ready)
    );

    iprm_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .sum_valid(sum_valid), .sum_data(sum_data), .sum_ready(sum_ready),
        .out_valid(m_valid), .out_item(m_data), .out_ready(m_ready)
    );
endmodule
`default_nettype wire

FILE: rtl/iprm_front.sv
// Front part: parses bytes, accumulates sums and captures fields per packet.
`default_nettype none
module iprm_front #(
    parameter int MAX_PACKET_BYTES    = iprm_pkg::MaxPacketBytes,
    parameter int MAX_ROUTE_ADDRESSES = iprm_pkg::MaxRouteAddresses
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire iprm_pkg::in_item_t     in_item,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [15:0]            exp_ip_id,
    input  wire logic [15:0]            exp_src_port,
    input  wire logic [15:0]            exp_dst_port,
    input  wire logic                   rr_enable,
    output logic                        sum_valid,
    output iprm_pkg::pkt_summary_t      sum_data,
    input  wire logic                   sum_ready
);
    localparam int CntW = $clog2(MAX_PACKET_BYTES + 1);

    logic [CntW-1:0] byte_count_reg;
    logic [5:0]  outer_hlen_reg, inner_hlen_reg;
    logic [15:0] total_len_reg, hdr_ck_reg, icmp_ck_reg;
    logic [16:0] hdr_sum_reg, icmp_sum_reg;
    logic [7:0]  ver_reg, proto_reg, ctype_reg, ccode_reg, pttl_reg, ttl_reg;
    logic [7:0]  ptype_reg, opt_reg, rptr_reg;
    logic [15:0] id_reg, inner_id_reg, sport_reg, dport_reg;
    logic [31:0] src_reg;
    logic [8:0][31:0] route_reg;

    logic        accept;
    logic [7:0]  b;
    logic [15:0] word;
    logic        take;
    logic [15:0] idx, r, t, ti;
    logic [16:0] hsum_now, isum_now;
    logic [3:0]  ihl_c;

    assign in_ready = !sum_valid || sum_ready;
    assign accept   = in_valid && in_ready;
    assign b        = in_item.data_byte;
    assign take     = 32'(byte_count_reg) < MAX_PACKET_BYTES;
    assign idx      = 16'(byte_count_reg);
    assign word     = idx[0] ? {8'h00, b} : {b, 8'h00};
    assign r        = idx - {10'd0, outer_hlen_reg};
    assign t        = r - 16'd8;
    assign ti       = t - {10'd0, inner_hlen_reg};
    assign ihl_c    = (b[3:0] < 4'd5) ? 4'd5 : b[3:0];

    // Sums including the current byte (for a last byte that is counted)
    always_comb begin
        hsum_now = hdr_sum_reg;
        isum_now = icmp_sum_reg;
        if (take && idx != 16'd0 && idx < {10'd0, outer_hlen_reg}) begin
            if (idx != 16'd10 && idx != 16'd11) hsum_now = iprm_pkg::oc_add(hdr_sum_reg, word);
        end else if (take && idx == 16'd0) begin
            hsum_now = iprm_pkg::oc_add(hdr_sum_reg, word);
        end else if (take && r != 16'd2 && r != 16'd3 && idx < total_len_reg) begin
            isum_now = iprm_pkg::oc_add(icmp_sum_reg, word);
        end
    end

    // Final values of fields whose last byte may be the current one
    logic [7:0]  f_ver, f_proto, f_ctype, f_ccode, f_pttl, f_ttl, f_ptype, f_opt, f_rptr;
    logic [15:0] f_tl, f_hck, f_ick, f_id, f_iid, f_sp, f_dp;
    logic [31:0] f_src;
    logic [5:0]  f_ihl;
    logic [8:0][31:0] f_route;
    logic        in_hdr;
    always_comb begin
        f_ver = ver_reg; f_proto = proto_reg; f_ctype = ctype_reg; f_ccode = ccode_reg;
        f_pttl = pttl_reg; f_ttl = ttl_reg; f_ptype = ptype_reg; f_opt = opt_reg;
        f_rptr = rptr_reg; f_tl = total_len_reg; f_hck = hdr_ck_reg; f_ick = icmp_ck_reg;
        f_id = id_reg; f_iid = inner_id_reg; f_sp = sport_reg; f_dp = dport_reg;
        f_src = src_reg; f_ihl = inner_hlen_reg; f_route = route_reg;
        in_hdr = (idx == 16'd0) || (idx < {10'd0, outer_hlen_reg});
        if (take) begin
            case (idx)
                16'd0:  f_ver = b;
                16'd2:  f_tl[15:8] = b;
                16'd3:  f_tl[7:0] = b;
                16'd4:  f_id[15:8] = b;
                16'd5:  f_id[7:0] = b;
                16'd8:  f_ttl = b;
                16'd9:  f_proto = b;
                16'd10: f_hck[15:8] = b;
                16'd11: f_hck[7:0] = b;
                16'd12: f_src[31:24] = b;
                16'd13: f_src[23:16] = b;
                16'd14: f_src[15:8] = b;
                16'd15: f_src[7:0] = b;
                default: ;
            endcase
            if (!in_hdr) begin
                case (r)
                    16'd0: f_ctype = b;
                    16'd1: f_ccode = b;
                    16'd2: f_ick[15:8] = b;
                    16'd3: f_ick[7:0] = b;
                    default: ;
                endcase
                if (r >= 16'd8) begin
                    case (t)
                        16'd0:  f_ihl = {b[3:0], 2'b00};
                        16'd4:  f_iid[15:8] = b;
                        16'd5:  f_iid[7:0] = b;
                        16'd8:  f_pttl = b;
                        16'd9:  f_ptype = b;
                        16'd20: f_opt = b;
                        16'd22: f_rptr = b;
                        default: ;
                    endcase
                    for (int k = 0; k < MAX_ROUTE_ADDRESSES; k++) begin
                        for (int p = 0; p < 4; p++) begin
                            if (t == 16'(23 + 4 * k + p)) f_route[k][8*(3-p) +: 8] = b;
                        end
                    end
                    // The quoted length byte sets the port window for itself too
                    if (t >= {10'd0, inner_hlen_reg} && ti < 16'd4
                        && (t != 16'd0 || b[3:0] == 4'd0)) begin
                        case (ti[1:0])
                            2'd0: f_sp[15:8] = b;
                            2'd1: f_sp[7:0] = b;
                            2'd2: f_dp[15:8] = b;
                            default: f_dp[7:0] = b;
                        endcase
                    end
                end
            end
        end
    end

    logic [CntW-1:0] cnt_now;
    assign cnt_now = take ? byte_count_reg + CntW'(1) : byte_count_reg;

    // Verdict at the last byte
    logic [3:0] verdict;
    logic [7:0] rcount;
    always_comb begin
        if (f_ver[7:4] != 4'd4) verdict = iprm_pkg::VerdictNotV4;
        else if (32'(cnt_now) < 20) verdict = iprm_pkg::VerdictShort;
        else if (32'(cnt_now) < 32'(f_tl)) verdict = iprm_pkg::VerdictTrunc;
        else if (~hsum_now[15:0] != f_hck) verdict = iprm_pkg::VerdictIpSum;
        else if (f_proto != 8'd1) verdict = iprm_pkg::VerdictNotIcmp;
        else if (~isum_now[15:0] != f_ick) verdict = iprm_pkg::VerdictIcmpSum;
        else if (f_ctype != 8'd11 && f_ctype != 8'd3) verdict = iprm_pkg::VerdictOtherType;
        else if (f_ptype != 8'd17 || f_iid != exp_ip_id || f_sp != exp_src_port
                 || f_dp != exp_dst_port) verdict = iprm_pkg::VerdictNoMatch;
        else verdict = iprm_pkg::VerdictMatch;
        rcount = 8'd0;
        if (verdict == iprm_pkg::VerdictMatch && rr_enable && f_ihl > 6'd20
            && f_opt == iprm_pkg::RrOptionType && f_rptr >= 8'd4) begin
            rcount = (f_rptr - 8'd4) >> 2;
            if (32'(rcount) > MAX_ROUTE_ADDRESSES) rcount = 8'(MAX_ROUTE_ADDRESSES);
        end
    end

    // Packet state registers
    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && in_item.last_byte)) begin
            byte_count_reg <= '0; outer_hlen_reg <= '0; inner_hlen_reg <= '0;
            total_len_reg <= '0; hdr_ck_reg <= '0; icmp_ck_reg <= '0;
            hdr_sum_reg <= '0; icmp_sum_reg <= '0;
            ver_reg <= '0; proto_reg <= '0; ctype_reg <= '0; ccode_reg <= '0;
            pttl_reg <= '0; ttl_reg <= '0; ptype_reg <= '0; opt_reg <= '0; rptr_reg <= '0;
            id_reg <= '0; inner_id_reg <= '0; sport_reg <= '0; dport_reg <= '0;
            src_reg <= '0; route_reg <= '0;
        end else if (accept) begin
            byte_count_reg <= cnt_now;
            if (take && idx == 16'd0) outer_hlen_reg <= {ihl_c, 2'b00};
            inner_hlen_reg <= f_ihl; total_len_reg <= f_tl; hdr_ck_reg <= f_hck;
            icmp_ck_reg <= f_ick; hdr_sum_reg <= hsum_now; icmp_sum_reg <= isum_now;
            ver_reg <= f_ver; proto_reg <= f_proto; ctype_reg <= f_ctype;
            ccode_reg <= f_ccode; pttl_reg <= f_pttl; ttl_reg <= f_ttl;
            ptype_reg <= f_ptype; opt_reg <= f_opt; rptr_reg <= f_rptr;
            id_reg <= f_id; inner_id_reg <= f_iid; sport_reg <= f_sp; dport_reg <= f_dp;
            src_reg <= f_src; route_reg <= f_route;
        end
    end

    // Summary handoff register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_valid <= 1'b0;
        end else if (accept && in_item.last_byte) begin
            sum_valid <= 1'b1;
        end else if (sum_ready) begin
            sum_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && in_item.last_byte) begin
            sum_data.verdict      <= verdict;
            sum_data.reply_source <= f_src;
            sum_data.reply_ttl    <= f_ttl;
            sum_data.icmp_type    <= f_ctype;
            sum_data.icmp_code    <= f_ccode;
            sum_data.reply_ip_id  <= f_id;
            sum_data.payload_ttl  <= f_pttl;
            sum_data.count        <= rcount[3:0];
            sum_data.routes       <= f_route;
        end
    end

`ifndef SYNTHESIS
    a_sum_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        sum_valid && !sum_ready |=> sum_valid && $stable(sum_data))
        else $error("summary changed while stalled");
    a_no_accept_full: assert property (@(posedge aclk) disable iff (!aresetn)
        sum_valid && !sum_ready |-> !in_ready)
        else $error("front accepted while summary stalled");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sum_valid |-> 32'(sum_data.count) <= MAX_ROUTE_ADDRESSES)
        else $error("route count out of range");
`endif
endmodule
`default_nettype wire

FILE: rtl/iprm_back.sv
// Back part: a two-entry summary queue and the result sequencer.
`default_nettype none
module iprm_back (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   sum_valid,
    input  wire iprm_pkg::pkt_summary_t sum_data,
    output logic                        sum_ready,
    output logic                        out_valid,
    output iprm_pkg::out_item_t         out_item,
    input  wire logic                   out_ready
);
    iprm_pkg::pkt_summary_t q_reg [2];
    logic [1:0] q_cnt_reg;
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [3:0] k_reg;
    logic       push, pop, fire;
    iprm_pkg::pkt_summary_t h;

    assign h         = q_reg[rd_ptr_reg];
    assign sum_ready = q_cnt_reg != 2'd2;
    assign push      = sum_valid && sum_ready;
    assign out_valid = q_cnt_reg != 2'd0;
    assign fire      = out_valid && out_ready;
    assign pop       = fire && (k_reg == h.count);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_cnt_reg <= '0; wr_ptr_reg <= 1'b0; rd_ptr_reg <= 1'b0; k_reg <= '0;
        end else begin
            q_cnt_reg <= q_cnt_reg + {1'b0, push} - {1'b0, pop};
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
                k_reg <= '0;
            end else if (fire) begin
                k_reg <= k_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) q_reg[wr_ptr_reg] <= sum_data;
    end

    // Result fields for the current index
    always_comb begin
        out_item.kind          = k_reg != 4'd0;
        out_item.verdict       = h.verdict;
        out_item.reply_source  = h.reply_source;
        out_item.reply_ttl     = h.reply_ttl;
        out_item.icmp_type     = h.icmp_type;
        out_item.icmp_code     = h.icmp_code;
        out_item.reply_ip_id   = h.reply_ip_id;
        out_item.payload_ttl   = h.payload_ttl;
        out_item.route_address = (k_reg == 4'd0) ? 32'd0 : h.routes[k_reg - 4'd1];
        out_item.last_result   = k_reg == h.count;
    end

`ifndef SYNTHESIS
    a_k_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> k_reg <= h.count)
        else $error("route index past count");
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_cnt_reg <= 2'd2)
        else $error("queue overflow");
    a_kind_route: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && out_item.kind |-> out_item.verdict == iprm_pkg::VerdictMatch)
        else $error("route result without match");
`endif
endmodule
`default_nettype wire
